// File: rtl/radial_scorch_stamp_blend_macros.svh
// ----------------------------------------------------------------------------
// Radial scorch stamp blend assertion macros
// Shared concurrent assertion wrappers, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef RADIAL_SCORCH_STAMP_BLEND_MACROS_SVH
`define RADIAL_SCORCH_STAMP_BLEND_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RSSB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RSSB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSSB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RSSB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/rssb_pkg.sv
// ----------------------------------------------------------------------------
// Radial scorch stamp blend package
// Constants, stage types and step functions for the blend pipeline.
// ----------------------------------------------------------------------------
package rssb_pkg;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [31:0] DIV6_MAGIC  = 32'hAAAAAAAB;
    localparam logic [31:0] DIV15_MAGIC = 32'h88888889;
    localparam logic [16:0] ONE_Q16     = 17'h10000;

    localparam logic [2:0] REG_CENTRE_X = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y = 3'd1;
    localparam logic [2:0] REG_RADIUS   = 3'd2;
    localparam logic [2:0] REG_CPP_X    = 3'd3;
    localparam logic [2:0] REG_CPP_Y    = 3'd4;
    localparam logic [2:0] REG_GREY     = 3'd5;

    typedef struct packed {
        logic [26:0] rem;
        logic [23:0] root;
        logic [47:0] rest;
    } sq_t;

    typedef struct packed {
        logic [22:0] rem;
        logic [16:0] q;
    } dv_t;

    // two radicand bit pairs per stage
    function automatic sq_t sq_pair(sq_t a);
        sq_t         s;
        logic [26:0] r;
        logic [26:0] tr;
        s = a;
        for (int i = 0; i < 2; i++) begin
            r  = {s.rem[24:0], s.rest[47:46]};
            tr = {1'b0, s.root, 2'b01};
            if (r >= tr) begin
                s.rem  = r - tr;
                s.root = {s.root[22:0], 1'b1};
            end else begin
                s.rem  = r;
                s.root = {s.root[22:0], 1'b0};
            end
            s.rest = {s.rest[45:0], 2'b00};
        end
        return s;
    endfunction

    // four quotient bits per stage
    function automatic dv_t dv_quad(dv_t a, logic [22:0] b);
        dv_t         d;
        logic [23:0] r2;
        d = a;
        for (int i = 0; i < 4; i++) begin
            r2 = {d.rem, 1'b0};
            if (r2 >= {1'b0, b}) begin
                d.rem = 23'(r2 - {1'b0, b});
                d.q   = {d.q[15:0], 1'b1};
            end else begin
                d.rem = r2[22:0];
                d.q   = {d.q[15:0], 1'b0};
            end
        end
        return d;
    endfunction

endpackage

// File: rtl/radial_scorch_stamp_blend.sv
// ----------------------------------------------------------------------------
// Radial scorch stamp blend
// Blends a radial scorch stamp into a stream of texels, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one texel per transaction (coordinates, old color, scorch
//   sample). m_ channel: blended color in m_tdata, covered flag in m_tuser.
//   APB port sets centre, radius, cells-per-pixel scales and grey mode;
//   write only while the pipeline is empty.
// Throughput: one texel per cycle unless stalled. The pipeline has 29 register stages:
//   offset multiply, abs/compare, squares, sum, 12 square-root stages of
//   two result bits, divide setup and 4 divide stages of four quotient bits,
//   6 polynomial stages for the sine, blend products and the output register.
// Reset: all stage valid bits clear, registers return to defaults
//   (centre 0, radius 0, scales 1.0, grey mode off).
// Stall: when m_tready is low with a result held, the whole pipeline
//   freezes and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "radial_scorch_stamp_blend_macros.svh"

module radial_scorch_stamp_blend #(
    parameter int TEXTURE_SIZE     = 1024,
    parameter int MAX_RADIUS_CELLS = 49
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_x, pixel_y, old_red, old_green, old_blue,
    // scorch_red, scorch_green, scorch_blue
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // new_red, new_green, new_blue
    output logic [23:0] m_tdata,
    // covered
    output logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RADMAX = MAX_RADIUS_CELLS * 256 - 1;
    localparam int NST    = 29;

    logic [12:0] centre_x_reg, centre_y_reg;
    logic [13:0] radius_reg;
    logic [23:0] cpp_x_reg, cpp_y_reg;
    logic        grey_reg;

    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            radius_reg   <= '0;
            cpp_x_reg    <= 24'h010000;
            cpp_y_reg    <= 24'h010000;
            grey_reg     <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                rssb_pkg::REG_CENTRE_X: centre_x_reg <= pwdata[12:0];
                rssb_pkg::REG_CENTRE_Y: centre_y_reg <= pwdata[12:0];
                rssb_pkg::REG_RADIUS:   radius_reg   <= pwdata[13:0];
                rssb_pkg::REG_CPP_X:    cpp_x_reg    <= pwdata[23:0];
                rssb_pkg::REG_CPP_Y:    cpp_y_reg    <= pwdata[23:0];
                rssb_pkg::REG_GREY:     grey_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            rssb_pkg::REG_CENTRE_X: prdata = 32'(centre_x_reg);
            rssb_pkg::REG_CENTRE_Y: prdata = 32'(centre_y_reg);
            rssb_pkg::REG_RADIUS:   prdata = 32'(radius_reg);
            rssb_pkg::REG_CPP_X:    prdata = 32'(cpp_x_reg);
            rssb_pkg::REG_CPP_Y:    prdata = 32'(cpp_y_reg);
            rssb_pkg::REG_GREY:     prdata = 32'(grey_reg);
            default:                prdata = '0;
        endcase
    end

    // effective radius in Q.17
    logic [13:0] rad_sat;
    logic [22:0] r17;
    assign rad_sat = (32'(radius_reg) > RADMAX) ? 14'(RADMAX) : radius_reg;
    assign r17     = {rad_sat, 9'b0};

    // pipeline control
    logic [NST:1] valid_reg;
    logic [21:1]  ok_reg;
    logic         en;
    assign en       = m_tready || !valid_reg[NST];
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NST-1:1], s_tvalid};
        end
    end

    // side data: old color [23:0], scorch color [47:24]
    logic [47:0] side_reg [1:28];
    logic [7:0]  sc_g, sc_b;
    assign sc_g = grey_reg ? s_tdata[55:48] : s_tdata[63:56];
    assign sc_b = grey_reg ? s_tdata[55:48] : s_tdata[71:64];

    // stage 1: texel centre times scale
    logic [36:0] posx_reg, posy_reg;
    logic        in_tex;
    assign in_tex = ({1'b0, s_tdata[11:0]} < 13'(TEXTURE_SIZE))
                 && ({1'b0, s_tdata[23:12]} < 13'(TEXTURE_SIZE))
                 && (rad_sat != '0);

    // stage 2: offset magnitude
    logic signed [38:0] offx, offy;
    logic [38:0]        magx, magy;
    logic [22:0]        ax_reg, ay_reg;
    assign offx = $signed({2'b00, posx_reg}) - (39'($signed(centre_x_reg)) <<< 17);
    assign offy = $signed({2'b00, posy_reg}) - (39'($signed(centre_y_reg)) <<< 17);
    assign magx = offx[38] ? 39'(-offx) : 39'(offx);
    assign magy = offy[38] ? 39'(-offy) : 39'(offy);

    // stage 3 squares, stage 4 sum, stages 5..16 square root
    logic [45:0]     sqx_reg, sqy_reg;
    rssb_pkg::sq_t   sq_reg [4:16];

    // stage 17 divide setup, stages 18..21 divide
    rssb_pkg::dv_t   dv_reg [17:21];
    logic [22:0]     dv_a;
    logic            d_in;
    assign d_in = (sq_reg[16].root < {1'b0, r17});
    assign dv_a = (ok_reg[16] && d_in) ? 23'(r17 - sq_reg[16].root[22:0]) : '0;

    // stages 22..27 coverage polynomial
    logic [16:0]  t_val;
    logic [47:0]  xp;
    logic [61:0]  x2p;
    logic [62:0]  x3p;
    logic [63:0]  x5p;
    logic [30:0]  x_reg [22:26];
    logic [31:0]  x2_reg, x2b_reg, x3_reg;
    logic [33:0]  x5_reg;
    logic [63:0]  p6_reg;
    logic [29:0]  d6_reg;
    logic [62:0]  p120_reg;
    logic [32:0]  s_val;
    logic [34:0]  s3;
    logic [20:0]  cov_raw;
    logic [16:0]  cov_reg;
    assign t_val   = ok_reg[21] ? dv_reg[21].q : '0;
    assign xp      = 48'(t_val) * 48'(rssb_pkg::HALF_PI_Q30);
    assign x2p     = 62'(x_reg[22]) * 62'(x_reg[22]);
    assign x3p     = 63'(x2_reg) * 63'(x_reg[23]);
    assign x5p     = 64'(x3_reg) * 64'(x2b_reg);
    assign s_val   = 33'(x_reg[26]) - 33'(d6_reg) + 33'(p120_reg[62:35]);
    assign s3      = 35'(s_val) * 35'd3;
    assign cov_raw = s3[34:14];

    // stages 28..29 blend
    logic [25:0]  sum_reg [0:2];
    logic         covd_reg;
    logic [16:0]  inv_cov;
    logic [23:0]  rgb_reg;
    logic         cov_out_reg;
    assign inv_cov = 17'(rssb_pkg::ONE_Q16 - cov_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[1] <= {sc_b, sc_g, s_tdata[55:48], s_tdata[47:24]};
            for (int k = 2; k <= 28; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            ok_reg[1] <= in_tex;
            posx_reg  <= 37'({s_tdata[11:0], 1'b1}) * 37'(cpp_x_reg);
            posy_reg  <= 37'({s_tdata[23:12], 1'b1}) * 37'(cpp_y_reg);

            ok_reg[2] <= ok_reg[1] && (magx < 39'(r17)) && (magy < 39'(r17));
            ax_reg    <= magx[22:0];
            ay_reg    <= magy[22:0];

            ok_reg[3] <= ok_reg[2];
            sqx_reg   <= 46'(ax_reg) * 46'(ax_reg);
            sqy_reg   <= 46'(ay_reg) * 46'(ay_reg);

            ok_reg[4]      <= ok_reg[3];
            sq_reg[4].rem  <= '0;
            sq_reg[4].root <= '0;
            sq_reg[4].rest <= 48'(47'(sqx_reg) + 47'(sqy_reg));
            for (int k = 5; k <= 16; k++) begin
                ok_reg[k] <= ok_reg[k-1];
                sq_reg[k] <= rssb_pkg::sq_pair(sq_reg[k-1]);
            end

            ok_reg[17]    <= ok_reg[16] && d_in;
            dv_reg[17].q  <= {16'b0, (dv_a == r17)};
            dv_reg[17].rem <= (dv_a == r17) ? '0 : dv_a;
            for (int k = 18; k <= 21; k++) begin
                ok_reg[k] <= ok_reg[k-1];
                dv_reg[k] <= rssb_pkg::dv_quad(dv_reg[k-1], r17);
            end

            x_reg[22] <= xp[46:16];
            for (int k = 23; k <= 26; k++) begin
                x_reg[k] <= x_reg[k-1];
            end
            x2_reg   <= x2p[61:30];
            x2b_reg  <= x2_reg;
            x3_reg   <= x3p[61:30];
            x5_reg   <= x5p[63:30];
            p6_reg   <= 64'(x3_reg) * 64'(rssb_pkg::DIV6_MAGIC);
            d6_reg   <= p6_reg[63:34];
            p120_reg <= 63'(x5_reg[33:3]) * 63'(rssb_pkg::DIV15_MAGIC);
            cov_reg  <= (cov_raw > 21'(rssb_pkg::ONE_Q16)) ? rssb_pkg::ONE_Q16
                                                             : cov_raw[16:0];

            covd_reg <= (cov_reg != '0);
            for (int c = 0; c < 3; c++) begin
                sum_reg[c] <= 26'(25'(side_reg[27][24+8*c +: 8]) * 25'(cov_reg))
                            + 26'(25'(side_reg[27][8*c +: 8]) * 25'(inv_cov));
            end

            cov_out_reg <= covd_reg;
            for (int c = 0; c < 3; c++) begin
                if (!covd_reg) begin
                    rgb_reg[8*c +: 8] <= side_reg[28][8*c +: 8];
                end else if (sum_reg[c][25:16] > 10'd255) begin
                    rgb_reg[8*c +: 8] <= 8'hFF;
                end else begin
                    rgb_reg[8*c +: 8] <= sum_reg[c][23:16];
                end
            end
        end
    end

    assign m_tvalid = valid_reg[NST];
    assign m_tdata  = rgb_reg;
    assign m_tuser  = cov_out_reg;

    `RSSB_ASSERT_NXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_tvalid)
    `RSSB_ASSERT_NXT(a_stall_holds, aclk, aresetn, !en, $stable(valid_reg))
    `RSSB_ASSERT_NXT(a_enter, aclk, aresetn, en && s_tvalid, valid_reg[1])
    `RSSB_ASSERT_NXT(a_advance, aclk, aresetn, en && valid_reg[NST-1], m_tvalid)

endmodule
